/* design/tcc_pkg.sv */
package tcc_pkg;

  // Screen and tab geometry
  localparam int unsigned MaxCols  = 256;
  localparam int unsigned MaxRows  = 128;
  localparam int unsigned TabWidth = 4;

  localparam int unsigned ColW  = $clog2(MaxCols);      // stored cursor column
  localparam int unsigned RowW  = $clog2(MaxRows);      // stored cursor row
  localparam int unsigned ColsW = $clog2(MaxCols) + 1;  // num_cols register
  localparam int unsigned RowsW = $clog2(MaxRows) + 1;  // num_rows register

  // Reset values of the configuration registers
  localparam logic [ColsW-1:0] ColsReset = ColsW'(80);
  localparam logic [RowsW-1:0] RowsReset = RowsW'(25);

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegEnable  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegNumCols = 2'd1;
  localparam logic [CfgIdxW-1:0] RegNumRows = 2'd2;
  localparam int unsigned CfgDataW = ColsW;

  // Operations and control characters
  localparam logic OpPut   = 1'b0;
  localparam logic OpClear = 1'b1;

  localparam logic [7:0] ChNul = 8'h00;
  localparam logic [7:0] ChBs  = 8'h08;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [7:0] ChCr  = 8'h0D;

  // Queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    CMD_DRAW   = 2'd0,
    CMD_BLANK  = 2'd1,
    CMD_SCROLL = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  // One classified input: an optional draw/blank/clear, then an optional scroll
  typedef struct packed {
    logic            has_first;
    cmd_e            first_cmd;
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    logic [7:0]      glyph;
    logic            has_scroll;
  } entry_t;

endpackage

/* design/tcc_front.sv */
module tcc_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tcc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tcc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         op_i,
  input  logic [7:0]                   char_i,
  output logic                         push_o,
  output tcc_pkg::entry_t              push_data_o,
  input  logic                         q_full_i
);

  logic                          enable_q;
  logic [tcc_pkg::ColsW-1:0]     num_cols_q;
  logic [tcc_pkg::RowsW-1:0]     num_rows_q;
  logic [tcc_pkg::ColW-1:0]      cursor_col_q, cursor_col_d;
  logic [tcc_pkg::RowW-1:0]      cursor_row_q, cursor_row_d;

  logic [tcc_pkg::ColsW-1:0]     cols_w;
  logic [tcc_pkg::RowsW-1:0]     rows_w;
  logic [tcc_pkg::ColsW:0]       col_n, col_w;
  logic [tcc_pkg::RowsW-1:0]     row_n, row_w;
  logic                          is_nul, scroll, accept, active;
  tcc_pkg::entry_t               rec;

  // Clamp screen size to 1..max
  always_comb begin
    if (num_cols_q == '0) begin
      cols_w = tcc_pkg::ColsW'(1);
    end else if (num_cols_q > tcc_pkg::ColsW'(tcc_pkg::MaxCols)) begin
      cols_w = tcc_pkg::ColsW'(tcc_pkg::MaxCols);
    end else begin
      cols_w = num_cols_q;
    end
    if (num_rows_q == '0) begin
      rows_w = tcc_pkg::RowsW'(1);
    end else if (num_rows_q > tcc_pkg::RowsW'(tcc_pkg::MaxRows)) begin
      rows_w = tcc_pkg::RowsW'(tcc_pkg::MaxRows);
    end else begin
      rows_w = num_rows_q;
    end
  end

  // Classify the character and step the cursor
  always_comb begin
    col_n          = (tcc_pkg::ColsW+1)'(cursor_col_q);
    row_n          = tcc_pkg::RowsW'(cursor_row_q);
    is_nul         = 1'b0;
    rec.has_first  = 1'b0;
    rec.first_cmd  = tcc_pkg::CMD_DRAW;
    rec.col        = cursor_col_q;
    rec.row        = cursor_row_q;
    rec.glyph      = '0;
    rec.has_scroll = 1'b0;
    case (char_i)
      tcc_pkg::ChNul: is_nul = 1'b1;
      tcc_pkg::ChLf: begin
        col_n = '0;
        row_n = row_n + tcc_pkg::RowsW'(1);
      end
      tcc_pkg::ChCr: col_n = '0;
      tcc_pkg::ChTab: col_n = col_n + (tcc_pkg::ColsW+1)'(tcc_pkg::TabWidth);
      tcc_pkg::ChBs: begin
        if (cursor_col_q != '0) begin
          col_n         = col_n - (tcc_pkg::ColsW+1)'(1);
          rec.has_first = 1'b1;
          rec.first_cmd = tcc_pkg::CMD_BLANK;
          rec.col       = cursor_col_q - tcc_pkg::ColW'(1);
        end else if (cursor_row_q != '0) begin
          // wrap back to the last column of the previous row
          row_n         = row_n - tcc_pkg::RowsW'(1);
          col_n         = (tcc_pkg::ColsW+1)'(cols_w - tcc_pkg::ColsW'(1));
          rec.has_first = 1'b1;
          rec.first_cmd = tcc_pkg::CMD_BLANK;
          rec.col       = tcc_pkg::ColW'(cols_w - tcc_pkg::ColsW'(1));
          rec.row       = cursor_row_q - tcc_pkg::RowW'(1);
        end
      end
      default: begin
        rec.has_first = 1'b1;
        rec.first_cmd = tcc_pkg::CMD_DRAW;
        rec.glyph     = char_i;
        col_n         = col_n + (tcc_pkg::ColsW+1)'(1);
      end
    endcase

    // column overflow wraps, row overflow scrolls
    if (col_n >= (tcc_pkg::ColsW+1)'(cols_w)) begin
      col_w = '0;
      row_w = row_n + tcc_pkg::RowsW'(1);
    end else begin
      col_w = col_n;
      row_w = row_n;
    end
    scroll         = (row_w >= rows_w);
    rec.has_scroll = scroll;
    cursor_col_d   = col_w[tcc_pkg::ColW-1:0];
    cursor_row_d   = scroll ? tcc_pkg::RowW'(rows_w - tcc_pkg::RowsW'(1))
                            : row_w[tcc_pkg::RowW-1:0];

    if (op_i == tcc_pkg::OpClear) begin
      rec.has_first  = 1'b1;
      rec.first_cmd  = tcc_pkg::CMD_CLEAR;
      rec.col        = '0;
      rec.row        = '0;
      rec.glyph      = '0;
      rec.has_scroll = 1'b0;
      cursor_col_d   = '0;
      cursor_row_d   = '0;
    end
  end

  assign in_ready_o  = !q_full_i;
  assign accept      = in_valid_i && in_ready_o;
  assign active      = accept && enable_q && (op_i == tcc_pkg::OpClear || !is_nul);
  assign push_o      = active && (rec.has_first || rec.has_scroll);
  assign push_data_o = rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b0;
      num_cols_q   <= tcc_pkg::ColsReset;
      num_rows_q   <= tcc_pkg::RowsReset;
      cursor_col_q <= '0;
      cursor_row_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tcc_pkg::RegEnable:  enable_q   <= cfg_data_i[0];
          tcc_pkg::RegNumCols: num_cols_q <= cfg_data_i;
          tcc_pkg::RegNumRows: num_rows_q <= cfg_data_i[tcc_pkg::RowsW-1:0];
          default: ;
        endcase
      end
      if (active) begin
        cursor_col_q <= cursor_col_d;
        cursor_row_q <= cursor_row_d;
      end
    end
  end

  // After any put or clear the cursor sits on a visible row
  a_row_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active && !cfg_we_i |=> tcc_pkg::RowsW'(cursor_row_q) < $past(rows_w))
    else $error("cursor row left the screen");

  // A clear accepted while enabled always produces a transaction for the back end
  a_clear_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && enable_q && op_i == tcc_pkg::OpClear |-> push_o)
    else $error("clear dropped");

endmodule

/* design/tcc_queue.sv */
module tcc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tcc_pkg::entry_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output tcc_pkg::entry_t head_o,
  output logic            empty_o
);

  tcc_pkg::entry_t             mem [tcc_pkg::QDepth];
  logic [tcc_pkg::QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [tcc_pkg::QCntW-1:0]   count_q;

  assign full_o  = (count_q == tcc_pkg::QCntW'(tcc_pkg::QDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + tcc_pkg::QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + tcc_pkg::QPtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + tcc_pkg::QCntW'(1);
        2'b01:   count_q <= count_q - tcc_pkg::QCntW'(1);
        default: ;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= tcc_pkg::QCntW'(tcc_pkg::QDepth))
    else $error("queue count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");

endmodule

/* design/tcc_back.sv */
module tcc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tcc_pkg::entry_t             head_i,
  input  logic                        empty_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output tcc_pkg::cmd_e               cmd_o,
  output logic [tcc_pkg::ColW-1:0]    col_o,
  output logic [tcc_pkg::RowW-1:0]    row_o,
  output logic [7:0]                  glyph_o,
  output logic                        last_o
);

  logic                       valid_q;
  logic                       phase_q, phase_d;
  tcc_pkg::cmd_e              cmd_q, cmd_d;
  logic [tcc_pkg::ColW-1:0]   col_q, col_d;
  logic [tcc_pkg::RowW-1:0]   row_q, row_d;
  logic [7:0]                 glyph_q, glyph_d;
  logic                       last_q, last_d;
  logic                       load, take_first;

  assign load       = !empty_i && (!valid_q || out_ready_i);
  assign take_first = !phase_q && head_i.has_first;

  // Emit the first command of the head entry, then its scroll if any
  always_comb begin
    if (take_first) begin
      cmd_d   = head_i.first_cmd;
      col_d   = head_i.col;
      row_d   = head_i.row;
      glyph_d = head_i.glyph;
      last_d  = !head_i.has_scroll;
    end else begin
      cmd_d   = tcc_pkg::CMD_SCROLL;
      col_d   = '0;
      row_d   = '0;
      glyph_d = '0;
      last_d  = 1'b1;
    end
    phase_d = load ? (take_first && head_i.has_scroll) : phase_q;
  end

  assign pop_o = load && !(take_first && head_i.has_scroll);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q   <= cmd_d;
      col_q   <= col_d;
      row_q   <= row_d;
      glyph_q <= glyph_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o = valid_q;
  assign cmd_o       = cmd_q;
  assign col_o       = col_q;
  assign row_o       = row_q;
  assign glyph_o     = glyph_q;
  assign last_o      = last_q;

  // Second half of a two-command entry keeps its entry at the queue head
  a_phase_holds_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> !empty_i)
    else $error("scroll pending with empty queue");

endmodule

/* design/text_console_cursor_control.sv */
// Text console cursor control.
// Input stream s_axis: one transaction per character byte (tuser = 0) or
// clear-screen request (tuser = 1). The block tracks the cursor column and
// row and turns each transaction into zero, one or two draw commands on
// m_axis: draw glyph, blank cell, scroll up one row, clear screen. tlast
// marks the final command of one input transaction.
// Configuration: cfg_we_i writes register cfg_idx_i (0 enable, 1 num_cols,
// 2 num_rows) with cfg_data_i at the clock edge; write only while idle.
// Structure: the front end classifies each character combinationally and
// steps the cursor register, pushes at most one entry into a four-deep queue,
// and the back end expands each entry into its commands through a registered
// output stage. Throughput: one input transaction per cycle while the queue
// is not full; the back end delivers one command per cycle while m_axis is
// not stalled, so inputs that cause two commands (draw or blank plus a
// scroll) take two output transfers. An accepted input's entry is written into
// the queue, then loaded into the output register that drives m_axis_tvalid.
// When m_axis stalls, the output register holds its command, the queue fills
// and s_axis_tready drops once the queue is full.
// Reset: the cursor homes to column 0, row 0, enable clears, num_cols = 80,
// num_rows = 25, the queue empties; there is no clearing pass.
module text_console_cursor_control (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tcc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tcc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [7:0] char_code
  input  logic                         s_axis_tuser,   // [0] operation
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [23:0]                  m_axis_tdata,   // [7:0] cell_col,
                                                       // [14:8] cell_row,
                                                       // [22:15] glyph, [23] 0
  output logic [1:0]                   m_axis_tuser,   // [1:0] command
  output logic                         m_axis_tlast    // last
);

  logic                      push, q_full, pop, q_empty;
  tcc_pkg::entry_t           push_data, head;
  tcc_pkg::cmd_e             cmd;
  logic [tcc_pkg::ColW-1:0]  col;
  logic [tcc_pkg::RowW-1:0]  row;
  logic [7:0]                glyph;

  // Classify and step the cursor
  tcc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tuser),
    .char_i      (s_axis_tdata),
    .push_o      (push),
    .push_data_o (push_data),
    .q_full_i    (q_full)
  );

  // Decouple the cursor logic from output stalls
  tcc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (q_empty)
  );

  // Expand entries into commands
  tcc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .col_o       (col),
    .row_o       (row),
    .glyph_o     (glyph),
    .last_o      (m_axis_tlast)
  );

  // Pack payload, lowest field first
  assign m_axis_tdata = {1'b0, glyph, row, col};
  assign m_axis_tuser = cmd;

endmodule
